// ===== hdl/line_clip_to_window_unit_assert.svh =====
`ifndef LINE_CLIP_TO_WINDOW_UNIT_ASSERT_SVH
`define LINE_CLIP_TO_WINDOW_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must hold in the cycle after a trigger
`define LCW_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);
`endif

// ===== hdl/lcw_pkg.sv =====
package lcw_pkg;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int MAX_PASSES = 8;
	localparam int PASS_W = 4;

	localparam int CODE_TOP = 0;
	localparam int CODE_BOTTOM = 1;
	localparam int CODE_RIGHT = 2;
	localparam int CODE_LEFT = 3;

	localparam logic [1:0] REG_LEFT = 2'd0;
	localparam logic [1:0] REG_RIGHT = 2'd1;
	localparam logic [1:0] REG_BOTTOM = 2'd2;
	localparam logic [1:0] REG_TOP = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_UPD,
		ST_DONE
	} lcw_state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic mul;
		logic div;
		logic upd;
		logic fin;
		logic fin_acc;
	} lcw_cmd_t;

	typedef struct packed {
		logic both_zero;
		logic and_nz;
		logic d_zero;
		logic div_last;
	} lcw_stat_t;
endpackage

// ===== hdl/lcw_ctrl.sv =====
module lcw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lcw_pkg::lcw_stat_t stat,
	output lcw_pkg::lcw_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	lcw_pkg::lcw_state_t state_q, state_d;
	logic [lcw_pkg::PASS_W-1:0] pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcw_pkg::ST_IDLE;
			pass_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				pass_q <= '0;
			else if (cmd.upd)
				pass_q <= pass_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != lcw_pkg::ST_IDLE);
		done = 1'b0;
		unique case (state_q)
			lcw_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = lcw_pkg::ST_CHECK;
				end
			end
			lcw_pkg::ST_CHECK: begin
				if (stat.both_zero) begin
					cmd.fin = 1'b1;
					cmd.fin_acc = 1'b1;
					state_d = lcw_pkg::ST_DONE;
				end else if (stat.and_nz || stat.d_zero
						|| pass_q == lcw_pkg::PASS_W'(lcw_pkg::MAX_PASSES)) begin
					cmd.fin = 1'b1;
					state_d = lcw_pkg::ST_DONE;
				end else begin
					cmd.setup = 1'b1;
					state_d = lcw_pkg::ST_MUL;
				end
			end
			lcw_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = lcw_pkg::ST_DIV;
			end
			lcw_pkg::ST_DIV: begin
				cmd.div = 1'b1;
				if (stat.div_last)
					state_d = lcw_pkg::ST_UPD;
			end
			lcw_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = lcw_pkg::ST_CHECK;
			end
			lcw_pkg::ST_DONE: begin
				done = 1'b1;
				state_d = lcw_pkg::ST_IDLE;
			end
			default: state_d = lcw_pkg::ST_IDLE;
		endcase
	end
endmodule

// ===== hdl/lcw_dpath.sv =====
module lcw_dpath #(
	parameter int COORD_WIDTH = lcw_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_addr,
	input  logic [COORD_WIDTH-1:0]        cfg_wdata,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  lcw_pkg::lcw_cmd_t             cmd,
	output lcw_pkg::lcw_stat_t            stat,
	output logic                          accepted,
	output logic signed [COORD_WIDTH-1:0] clip_start_x,
	output logic signed [COORD_WIDTH-1:0] clip_start_y,
	output logic signed [COORD_WIDTH-1:0] clip_end_x,
	output logic signed [COORD_WIDTH-1:0] clip_end_y
);
	localparam int W = COORD_WIDTH;
	localparam int PW = 2 * W + 2;
	localparam int CW = $clog2(PW);

	logic signed [W-1:0] left_q, right_q, bottom_q, top_q;
	logic signed [W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [3:0] c0, c1, c;
	logic vert;
	logic signed [W-1:0] edge_v, base_v;
	logic signed [W:0] a_v, b_v, d_v;
	logic [W:0] ua_q, ub_q, ud_q, rem_q;
	logic neg_q, vert_q, move0_q;
	logic signed [W-1:0] edge_q, base_q;
	logic [PW-1:0] p_q;
	logic [CW-1:0] cnt_q;
	logic [W+1:0] r2, r2_sub;
	logic signed [W+1:0] q_ext, sum;
	logic signed [W-1:0] new_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			right_q <= '0;
			bottom_q <= '0;
			top_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				lcw_pkg::REG_LEFT:   left_q <= cfg_wdata;
				lcw_pkg::REG_RIGHT:  right_q <= cfg_wdata;
				lcw_pkg::REG_BOTTOM: bottom_q <= cfg_wdata;
				lcw_pkg::REG_TOP:    top_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		c0 = '0;
		c1 = '0;
		c0[lcw_pkg::CODE_TOP] = y0_q > top_q;
		c0[lcw_pkg::CODE_BOTTOM] = y0_q < bottom_q;
		c0[lcw_pkg::CODE_RIGHT] = x0_q > right_q;
		c0[lcw_pkg::CODE_LEFT] = x0_q < left_q;
		c1[lcw_pkg::CODE_TOP] = y1_q > top_q;
		c1[lcw_pkg::CODE_BOTTOM] = y1_q < bottom_q;
		c1[lcw_pkg::CODE_RIGHT] = x1_q > right_q;
		c1[lcw_pkg::CODE_LEFT] = x1_q < left_q;
		c = (c0 != '0) ? c0 : c1;
		vert = c[lcw_pkg::CODE_TOP] | c[lcw_pkg::CODE_BOTTOM];
		if (vert) begin
			edge_v = c[lcw_pkg::CODE_TOP] ? top_q : bottom_q;
			base_v = x0_q;
			a_v = {x1_q[W-1], x1_q} - {x0_q[W-1], x0_q};
			b_v = {edge_v[W-1], edge_v} - {y0_q[W-1], y0_q};
			d_v = {y1_q[W-1], y1_q} - {y0_q[W-1], y0_q};
		end else begin
			edge_v = c[lcw_pkg::CODE_LEFT] ? left_q : right_q;
			base_v = y0_q;
			a_v = {y1_q[W-1], y1_q} - {y0_q[W-1], y0_q};
			b_v = {edge_v[W-1], edge_v} - {x0_q[W-1], x0_q};
			d_v = {x1_q[W-1], x1_q} - {x0_q[W-1], x0_q};
		end
		stat.both_zero = (c0 == '0) && (c1 == '0);
		stat.and_nz = (c0 & c1) != '0;
		stat.d_zero = (d_v == '0);
		stat.div_last = (cnt_q == CW'(PW - 1));
	end

	assign r2 = {rem_q, p_q[PW-1]};
	assign r2_sub = r2 - {1'b0, ud_q};
	assign q_ext = $signed({1'b0, p_q[W:0]});
	assign sum = {{2{base_q[W-1]}}, base_q} + (neg_q ? -q_ext : q_ext);
	assign new_v = sum[W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q <= start_x;
			y0_q <= start_y;
			x1_q <= end_x;
			y1_q <= end_y;
		end else if (cmd.upd) begin
			if (move0_q) begin
				x0_q <= vert_q ? new_v : edge_q;
				y0_q <= vert_q ? edge_q : new_v;
			end else begin
				x1_q <= vert_q ? new_v : edge_q;
				y1_q <= vert_q ? edge_q : new_v;
			end
		end
		if (cmd.setup) begin
			ua_q <= a_v[W] ? -a_v : a_v;
			ub_q <= b_v[W] ? -b_v : b_v;
			ud_q <= d_v[W] ? -d_v : d_v;
			neg_q <= a_v[W] ^ b_v[W] ^ d_v[W];
			vert_q <= vert;
			move0_q <= (c0 != '0);
			edge_q <= edge_v;
			base_q <= base_v;
		end
		if (cmd.mul) begin
			p_q <= PW'(ua_q) * PW'(ub_q);
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div) begin
			if (!r2_sub[W+1]) begin
				rem_q <= r2_sub[W:0];
				p_q <= {p_q[PW-2:0], 1'b1};
			end else begin
				rem_q <= r2[W:0];
				p_q <= {p_q[PW-2:0], 1'b0};
			end
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.fin) begin
			clip_start_x <= cmd.fin_acc ? x0_q : '0;
			clip_start_y <= cmd.fin_acc ? y0_q : '0;
			clip_end_x <= cmd.fin_acc ? x1_q : '0;
			clip_end_y <= cmd.fin_acc ? y1_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			accepted <= 1'b0;
		else if (cmd.fin)
			accepted <= cmd.fin_acc;
	end
endmodule

// ===== hdl/line_clip_to_window_unit.sv =====
// Cohen-Sutherland segment clipper. Pulse start while busy is low to launch one
// segment; the result appears on accepted and clip_* for exactly one cycle with
// done high and cannot be stalled, so the receiver must take it then. Each
// clipping pass runs the region test, the multiply, the bit-serial divider and
// an update; a segment in a proper window needs up to four passes, and the next
// segment is taken in the cycle after done, as busy holds start off until then.
// An inverted window can run to the eight-pass limit. Window registers are to
// be written by the user through cfg_we/cfg_addr/cfg_wdata only while the unit
// is idle; the block itself does not enforce it.
module line_clip_to_window_unit #(
	parameter int COORD_WIDTH = lcw_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_addr,
	input  logic [COORD_WIDTH-1:0]        cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	output logic                          done,
	output logic                          accepted,
	output logic signed [COORD_WIDTH-1:0] clip_start_x,
	output logic signed [COORD_WIDTH-1:0] clip_start_y,
	output logic signed [COORD_WIDTH-1:0] clip_end_x,
	output logic signed [COORD_WIDTH-1:0] clip_end_y
);
	lcw_pkg::lcw_cmd_t cmd;
	lcw_pkg::lcw_stat_t stat;

	lcw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	lcw_dpath #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.cmd         (cmd),
		.stat        (stat),
		.accepted    (accepted),
		.clip_start_x(clip_start_x),
		.clip_start_y(clip_start_y),
		.clip_end_x  (clip_end_x),
		.clip_end_y  (clip_end_y)
	);

`include "line_clip_to_window_unit_assert.svh"

	`LCW_ASSERT(a_done_busy, done |-> busy, "done outside busy")
	`LCW_ASSERT_NEXT(a_done_idle, done, !busy, "busy after done")
	`LCW_ASSERT(a_rose_busy, $rose(busy) |-> $past(start), "busy without start")
	`LCW_ASSERT(a_reject_zero, (done && !accepted) |-> (clip_start_x == '0 && clip_end_y == '0),
		"rejected segment not zeroed")
endmodule

// ===== tb/tb_line_clip_to_window_unit.sv =====
`timescale 1ns / 1ps

module tb_line_clip_to_window_unit;
	localparam int CW = lcw_pkg::COORD_WIDTH_DEF;
	localparam int SETTLE = 200;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		logic   acc;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} clip_t;

	typedef struct {
		bit     set_window;
		coord_t a;
		coord_t b;
		coord_t c;
		coord_t d;
		bit     typed;
		clip_t  want;
	} row_t;

	logic   clk;
	logic   arst_n;
	logic   cfg_we;
	logic   [1:0] cfg_addr;
	logic   [CW-1:0] cfg_wdata;
	logic   start;
	logic   busy;
	coord_t start_x, start_y, end_x, end_y;
	logic   done;
	logic   accepted;
	coord_t clip_start_x, clip_start_y, clip_end_x, clip_end_y;

	line_clip_to_window_unit #(.COORD_WIDTH(CW)) dut (.*);

	longint win_l, win_r, win_b, win_t;
	clip_t  clip_pending[$];
	bit     use_typed;
	clip_t  typed_want;
	int     mismatches;
	int     idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [3:0] region_code(longint x, longint y);
		logic [3:0] c;
		c = '0;
		c[lcw_pkg::CODE_TOP] = y > win_t;
		c[lcw_pkg::CODE_BOTTOM] = y < win_b;
		c[lcw_pkg::CODE_RIGHT] = x > win_r;
		c[lcw_pkg::CODE_LEFT] = x < win_l;
		return c;
	endfunction

	function automatic clip_t clip_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		longint x0, y0, x1, y1, x, y;
		logic [3:0] c0, c1, c;
		bit ok;
		bit stop;
		clip_t r;
		x0 = longint'(ax); y0 = longint'(ay); x1 = longint'(bx); y1 = longint'(by);
		c0 = region_code(x0, y0);
		c1 = region_code(x1, y1);
		ok = 1'b0;
		stop = 1'b0;
		for (int pass = 0; pass <= lcw_pkg::MAX_PASSES && !stop; pass++) begin
			if (c0 == 0 && c1 == 0) begin
				ok = 1'b1;
				stop = 1'b1;
			end else if ((c0 & c1) != 0 || pass == lcw_pkg::MAX_PASSES) begin
				stop = 1'b1;
			end else begin
				c = (c0 != 0) ? c0 : c1;
				if (c[lcw_pkg::CODE_TOP] || c[lcw_pkg::CODE_BOTTOM]) begin
					y = c[lcw_pkg::CODE_TOP] ? win_t : win_b;
					if (y1 == y0) stop = 1'b1;
					else x = x0 + ((x1 - x0) * (y - y0)) / (y1 - y0);
				end else begin
					x = c[lcw_pkg::CODE_LEFT] ? win_l : win_r;
					if (x1 == x0) stop = 1'b1;
					else y = y0 + ((y1 - y0) * (x - x0)) / (x1 - x0);
				end
				if (!stop) begin
					if (c0 != 0) begin
						x0 = x; y0 = y; c0 = region_code(x0, y0);
					end else begin
						x1 = x; y1 = y; c1 = region_code(x1, y1);
					end
				end
			end
		end
		r.acc = ok;
		r.sx = ok ? coord_t'(x0) : '0;
		r.sy = ok ? coord_t'(y0) : '0;
		r.ex = ok ? coord_t'(x1) : '0;
		r.ey = ok ? coord_t'(y1) : '0;
		return r;
	endfunction

	// register writes, transfers and result checks, all sampled at the clock edge
	always @(posedge clk) begin : mon
		clip_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_we) begin
				case (cfg_addr)
					lcw_pkg::REG_LEFT: win_l = longint'(coord_t'(cfg_wdata));
					lcw_pkg::REG_RIGHT: win_r = longint'(coord_t'(cfg_wdata));
					lcw_pkg::REG_BOTTOM: win_b = longint'(coord_t'(cfg_wdata));
					lcw_pkg::REG_TOP: win_t = longint'(coord_t'(cfg_wdata));
				endcase
			end
			if (start && !busy) begin
				moved = 1'b1;
				if (use_typed) clip_pending.push_back(typed_want);
				else clip_pending.push_back(clip_segment(start_x, start_y, end_x, end_y));
			end
			if (done) begin
				moved = 1'b1;
				if (clip_pending.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %0d (%0d,%0d)-(%0d,%0d) at %0t",
							accepted, clip_start_x, clip_start_y, clip_end_x,
							clip_end_y, $realtime);
				end else begin
					want = clip_pending.pop_front();
					if (accepted !== want.acc || clip_start_x !== want.sx
						|| clip_start_y !== want.sy || clip_end_x !== want.ex
						|| clip_end_y !== want.ey) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want %0d (%0d,%0d)-(%0d,%0d) got %0d (%0d,%0d)-(%0d,%0d)",
								want.acc, want.sx, want.sy, want.ex, want.ey, accepted,
								clip_start_x, clip_start_y, clip_end_x, clip_end_y);
					end
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// hold start high until the transfer; returns at the accepting edge
	task automatic send_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		bit took;
		start <= 1'b1;
		start_x <= ax;
		start_y <= ay;
		end_x <= bx;
		end_y <= by;
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic drain;
		start <= 1'b0;
		use_typed <= 1'b0;
		@(posedge clk);
		while (clip_pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_window(coord_t l, coord_t r, coord_t b, coord_t t);
		cfg_we <= 1'b1;
		cfg_addr <= lcw_pkg::REG_LEFT;
		cfg_wdata <= l;
		@(posedge clk);
		cfg_addr <= lcw_pkg::REG_RIGHT;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_addr <= lcw_pkg::REG_BOTTOM;
		cfg_wdata <= b;
		@(posedge clk);
		cfg_addr <= lcw_pkg::REG_TOP;
		cfg_wdata <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic coord_t near_coord(coord_t lo, coord_t hi);
		longint v;
		v = longint'(lo) - 200 + longint'($urandom_range(0, 400))
			+ (longint'(hi) - longint'(lo)) * longint'($urandom_range(0, 2)) / 2;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return coord_t'(v);
	endfunction

	function automatic clip_t typed_row(bit a, int sx, int sy, int ex, int ey);
		clip_t r;
		r.acc = a;
		r.sx = coord_t'(sx); r.sy = coord_t'(sy); r.ex = coord_t'(ex); r.ey = coord_t'(ey);
		return r;
	endfunction

	row_t plan[$];

	function automatic row_t mk(bit w, int a, int b, int c, int d, bit t, clip_t want);
		row_t r;
		r.set_window = w;
		r.a = coord_t'(a); r.b = coord_t'(b); r.c = coord_t'(c); r.d = coord_t'(d);
		r.typed = t; r.want = want;
		return r;
	endfunction

	initial begin
		clip_t z;
		coord_t wl, wr, wb, wt, a, b;
		int mode;
		bit quiet;
		z = typed_row(0, 0, 0, 0, 0);
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		start = 1'b0;
		start_x = '0; start_y = '0; end_x = '0; end_y = '0;
		use_typed = 1'b0;
		typed_want = z;
		mismatches = 0;
		idle_cycles = 0;
		win_l = 0; win_r = 0; win_b = 0; win_t = 0;

		// after reset the window is the single point at the origin
		plan.push_back(mk(0, 0, 0, 0, 0, 1, typed_row(1, 0, 0, 0, 0)));
		plan.push_back(mk(0, 5, 5, 7, 9, 1, z));
		plan.push_back(mk(0, -32768, -32768, 32767, 32767, 0, z));
		plan.push_back(mk(0, -5, 0, 5, 0, 1, typed_row(1, 0, 0, 0, 0)));
		plan.push_back(mk(1, -100, 100, -50, 50, 0, z));
		plan.push_back(mk(0, 10, 20, -30, 40, 1, typed_row(1, 10, 20, -30, 40)));
		plan.push_back(mk(0, -32768, 0, 32767, 0, 1, typed_row(1, -100, 0, 100, 0)));
		plan.push_back(mk(0, 0, 32767, 0, -32768, 1, typed_row(1, 0, 50, 0, -50)));
		plan.push_back(mk(0, -32768, -32768, -32768, 32767, 1, z));
		plan.push_back(mk(0, 32767, 32767, 32767, -32768, 1, z));
		plan.push_back(mk(0, -200, 60, 200, 60, 1, z));
		plan.push_back(mk(0, 0, -32768, 32767, -51, 1, z));
		plan.push_back(mk(0, -32768, -32768, 32767, 32767, 0, z));
		plan.push_back(mk(0, -150, 90, 130, -80, 0, z));
		plan.push_back(mk(0, 101, 0, 150, 45, 0, z));
		plan.push_back(mk(0, -120, 40, -40, 80, 0, z));
		plan.push_back(mk(0, 32767, -32768, -32768, 32767, 0, z));
		plan.push_back(mk(1, -32768, 32767, -32768, 32767, 0, z));
		plan.push_back(mk(0, -32768, -32768, 32767, 32767, 1,
			typed_row(1, -32768, -32768, 32767, 32767)));
		plan.push_back(mk(0, 32767, -32768, -32768, 32767, 0, z));
		// inverted window
		plan.push_back(mk(1, 100, -100, 50, -50, 0, z));
		plan.push_back(mk(0, 0, 0, 10, 10, 0, z));
		plan.push_back(mk(0, -32768, 0, 32767, 0, 0, z));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].set_window) begin
				drain();
				write_window(plan[i].a, plan[i].b, plan[i].c, plan[i].d);
			end else begin
				use_typed <= plan[i].typed;
				typed_want <= plan[i].want;
				send_segment(plan[i].a, plan[i].b, plan[i].c, plan[i].d);
			end
		end

		for (int phase = 0; phase < 8; phase++) begin
			drain();
			mode = int'($urandom_range(0, 5));
			wl = coord_t'($urandom); wr = coord_t'($urandom);
			wb = coord_t'($urandom); wt = coord_t'($urandom);
			if (mode < 3) begin
				if (wl > wr) begin a = wl; wl = wr; wr = a; end
				if (wb > wt) begin a = wb; wb = wt; wt = a; end
			end
			if (mode == 0) begin
				a = coord_t'(int'($urandom_range(0, 2000)) - 1000);
				b = coord_t'(int'($urandom_range(0, 2000)) - 1000);
				wl = a; wr = coord_t'(longint'(a) + longint'($urandom_range(0, 600)));
				wb = b; wt = coord_t'(longint'(b) + longint'($urandom_range(0, 600)));
			end
			if (phase == 6) begin
				wl = -32768; wr = 32767; wb = -32768; wt = 32767;
			end
			write_window(wl, wr, wb, wt);
			quiet = (phase == 7);
			for (int n = 0; n < 200; n++) begin
				if ($urandom_range(0, 2) == 0)
					send_segment(coord_t'($urandom), coord_t'($urandom),
						coord_t'($urandom), coord_t'($urandom));
				else
					send_segment(near_coord(wl, wr), near_coord(wb, wt),
						near_coord(wl, wr), near_coord(wb, wt));
				if (!quiet && $urandom_range(0, 3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 9)) @(posedge clk);
				end
			end
		end

		drain();
		if (mismatches == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
